FILE: rtl/jkloc_pkg.sv
// Package for the JSON top-level key locator.
// Holds the word types, phase and status codes, sizes and byte helpers.
// No dependencies.
package jkloc_pkg;

	localparam int KEY_MAX       = 32;
	localparam int POSITION_BITS = 16;
	localparam int DEPTH_BITS    = 16;
	localparam int KEY_IDX_BITS  = 6;
	localparam int KEY_WORDS     = 4;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [2:0] CFG_KEY_WORD3  = 3'd3;
	localparam logic [2:0] CFG_KEY_LENGTH = 3'd4;

	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NUL       = 8'h00;

	typedef enum logic [3:0] {
		PH_OPEN        = 4'd0,
		PH_KEY_START   = 4'd1,
		PH_KEY         = 4'd2,
		PH_COLON       = 4'd3,
		PH_VALUE_START = 4'd4,
		PH_SCALAR      = 4'd5,
		PH_STRING      = 4'd6,
		PH_CONTAINER   = 4'd7,
		PH_AFTER_VALUE = 4'd8,
		PH_DONE        = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_FOUND     = 2'd1,
		ST_MISSING   = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last;
	} text_word_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] value_offset;
	} result_word_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	// Clamp a position to the 16-bit offset field.
	function automatic logic [15:0] sat_offset(input logic [POSITION_BITS-1:0] v);
		logic [31:0] ext;
		ext = 32'(v);
		return (ext > 32'h0000_FFFF) ? 16'hFFFF : ext[15:0];
	endfunction

endpackage

FILE: rtl/json_top_level_key_locator_top.sv
// Top level of the JSON top-level key locator: input register, one decision
// stage and a result register. Depends on jkloc_pkg.

// Takes JSON text one byte per word and reports, for every byte, whether the
// configured key has been found among the members of the top-level object
// (with the offset of its value's first non-blank character), is still being
// searched for, or is missing. A NUL byte or a byte marked last ends the text;
// the next byte starts a new one. The block takes one byte per clock cycle
// when the result side keeps up; each result word is registered: the byte
// sits in the input register while the whole per-byte decision is made, and
// the result register loads the result when the decision stage advances.
// The input stalls only while a byte is held and the result word ahead of it
// is stalled.
// The key registers may be written only while no byte is in flight.
module json_top_level_key_locator_top
	import jkloc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    text_valid,
	output logic                    text_stall,
	input  text_word_t              text,
	output logic                    result_valid,
	input  logic                    result_stall,
	output result_word_t            result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [63:0]             cfg_data
);

	logic [KEY_WORDS-1:0][63:0] key_word_q;
	logic [KEY_IDX_BITS-1:0]    key_length_q;

	logic       s1_valid;
	text_word_t s1_word;
	logic       advance;

	phase_t                    phase_q, phase_d;
	logic                      escape_q, escape_d;
	logic                      inner_q, inner_d;
	logic [KEY_IDX_BITS-1:0]   key_index_q, key_index_d;
	logic                      mismatch_q, mismatch_d;
	logic [DEPTH_BITS-1:0]     depth_q, depth_d;
	logic                      close_brace_q, close_brace_d;
	logic [POSITION_BITS-1:0]  pos_q, pos_d;
	status_t                   outcome_q, outcome_d;
	logic [POSITION_BITS-1:0]  found_q, found_d;
	logic                      ended_q, ended_d;

	result_word_t result_d;
	result_word_t result_q;
	logic         result_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_word_q   <= '0;
			key_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index <= CFG_KEY_WORD3) begin
				key_word_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index == CFG_KEY_LENGTH) begin
				key_length_q <= cfg_data[KEY_IDX_BITS-1:0];
			end
		end
	end

	// Handshake: the decision stage advances whenever the result slot is free or draining.
	assign advance    = s1_valid && (!result_valid_q || !result_stall);
	assign text_stall = s1_valid && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= (text_valid && !text_stall) || (s1_valid && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			s1_word <= text;
		end
	end

	// Next state for one byte.
	always_comb begin
		logic [7:0]              b;
		logic [KEY_IDX_BITS-1:0] len_eff;
		logic [8*8*KEY_WORDS-1:0] key_flat;
		logic [7:0]              key_byte;
		logic [7:0]              open_ch;
		logic [7:0]              close_ch;
		logic [POSITION_BITS-1:0] pos_base;
		logic [POSITION_BITS-1:0] pos_inc;

		b        = s1_word.text_byte;
		len_eff  = (key_length_q > KEY_IDX_BITS'(KEY_MAX)) ? KEY_IDX_BITS'(KEY_MAX)
			: key_length_q;
		key_flat = key_word_q;

		phase_d       = phase_q;
		escape_d      = escape_q;
		inner_d       = inner_q;
		key_index_d   = key_index_q;
		mismatch_d    = mismatch_q;
		depth_d       = depth_q;
		close_brace_d = close_brace_q;
		pos_base      = pos_q;
		outcome_d     = outcome_q;
		found_d       = found_q;

		// Start a fresh text after an end marker.
		if (ended_q) begin
			phase_d       = PH_OPEN;
			escape_d      = 1'b0;
			inner_d       = 1'b0;
			key_index_d   = '0;
			mismatch_d    = 1'b0;
			depth_d       = '0;
			close_brace_d = 1'b0;
			pos_base      = '0;
			outcome_d     = ST_SEARCHING;
			found_d       = '0;
		end

		pos_inc  = (pos_base == '1) ? pos_base : pos_base + 1'b1;
		key_byte = key_flat[8*key_index_d[4:0] +: 8];
		open_ch  = close_brace_d ? CH_LBRACE : CH_LBRACKET;
		close_ch = close_brace_d ? CH_RBRACE : CH_RBRACKET;

		if (phase_d != PH_DONE) begin
			if (b == CH_NUL) begin
				if (phase_d == PH_VALUE_START && !mismatch_d) begin
					outcome_d = ST_FOUND;
					found_d   = pos_base;
				end else begin
					outcome_d = ST_MISSING;
				end
				phase_d = PH_DONE;
			end else begin
				case (phase_d)
					PH_OPEN: begin
						if (!is_blank(b)) begin
							if (b == CH_LBRACE) begin
								phase_d = PH_KEY_START;
							end else begin
								outcome_d = ST_MISSING;
								phase_d   = PH_DONE;
							end
						end
					end
					PH_KEY_START: begin
						if (!is_blank(b)) begin
							if (b == CH_QUOTE) begin
								phase_d     = PH_KEY;
								key_index_d = '0;
								mismatch_d  = 1'b0;
								escape_d    = 1'b0;
							end else begin
								outcome_d = ST_MISSING;
								phase_d   = PH_DONE;
							end
						end
					end
					PH_KEY: begin
						if (!escape_d && b == CH_QUOTE) begin
							if (key_index_d != len_eff) begin
								mismatch_d = 1'b1;
							end
							phase_d = PH_COLON;
						end else begin
							if (escape_d) begin
								escape_d = 1'b0;
							end else if (b == CH_BACKSLASH) begin
								escape_d = 1'b1;
							end
							if (key_index_d >= len_eff || b != key_byte) begin
								mismatch_d = 1'b1;
							end
							if (key_index_d != '1) begin
								key_index_d = key_index_d + 1'b1;
							end
						end
					end
					PH_COLON: begin
						if (!is_blank(b)) begin
							if (b == CH_COLON) begin
								phase_d = PH_VALUE_START;
							end else begin
								outcome_d = ST_MISSING;
								phase_d   = PH_DONE;
							end
						end
					end
					PH_VALUE_START: begin
						if (!is_blank(b)) begin
							if (!mismatch_d) begin
								outcome_d = ST_FOUND;
								found_d   = pos_base;
								phase_d   = PH_DONE;
							end else if (b == CH_QUOTE) begin
								escape_d = 1'b0;
								phase_d  = PH_STRING;
							end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
								close_brace_d = (b == CH_LBRACE);
								depth_d       = DEPTH_BITS'(1);
								inner_d       = 1'b0;
								escape_d      = 1'b0;
								phase_d       = PH_CONTAINER;
							end else if (b == CH_COMMA) begin
								phase_d = PH_KEY_START;
							end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
								outcome_d = ST_MISSING;
								phase_d   = PH_DONE;
							end else begin
								phase_d = PH_SCALAR;
							end
						end
					end
					PH_SCALAR: begin
						if (b == CH_COMMA) begin
							phase_d = PH_KEY_START;
						end else if (is_blank(b)) begin
							phase_d = PH_AFTER_VALUE;
						end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
							outcome_d = ST_MISSING;
							phase_d   = PH_DONE;
						end
					end
					PH_STRING: begin
						if (escape_d) begin
							escape_d = 1'b0;
						end else if (b == CH_BACKSLASH) begin
							escape_d = 1'b1;
						end else if (b == CH_QUOTE) begin
							phase_d = PH_AFTER_VALUE;
						end
					end
					PH_CONTAINER: begin
						// Count only the container's own bracket type; pass over strings.
						if (inner_d) begin
							if (escape_d) begin
								escape_d = 1'b0;
							end else if (b == CH_BACKSLASH) begin
								escape_d = 1'b1;
							end else if (b == CH_QUOTE) begin
								inner_d = 1'b0;
							end
						end else if (b == CH_QUOTE) begin
							inner_d  = 1'b1;
							escape_d = 1'b0;
						end else if (b == open_ch) begin
							if (depth_d != '1) begin
								depth_d = depth_d + 1'b1;
							end
						end else if (b == close_ch) begin
							if (depth_d != '0) begin
								depth_d = depth_d - 1'b1;
							end
							if (depth_d == '0) begin
								phase_d = PH_AFTER_VALUE;
							end
						end
					end
					PH_AFTER_VALUE: begin
						if (!is_blank(b)) begin
							if (b == CH_COMMA) begin
								phase_d = PH_KEY_START;
							end else begin
								outcome_d = ST_MISSING;
								phase_d   = PH_DONE;
							end
						end
					end
					default: begin
					end
				endcase

				// A text cut short by the last flag ends just past this byte.
				if (s1_word.last && phase_d != PH_DONE) begin
					if (phase_d == PH_VALUE_START && !mismatch_d) begin
						outcome_d = ST_FOUND;
						found_d   = pos_inc;
					end else begin
						outcome_d = ST_MISSING;
					end
					phase_d = PH_DONE;
				end
			end
		end

		ended_d = (b == CH_NUL) || s1_word.last;
		pos_d   = pos_inc;
	end

	// Result word for the byte in the decision stage.
	always_comb begin
		result_d.status       = outcome_d;
		result_d.value_offset = (outcome_d == ST_FOUND) ? sat_offset(found_d) : 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_OPEN;
			escape_q      <= 1'b0;
			inner_q       <= 1'b0;
			key_index_q   <= '0;
			mismatch_q    <= 1'b0;
			depth_q       <= '0;
			close_brace_q <= 1'b0;
			pos_q         <= '0;
			outcome_q     <= ST_SEARCHING;
			found_q       <= '0;
			ended_q       <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			escape_q      <= escape_d;
			inner_q       <= inner_d;
			key_index_q   <= key_index_d;
			mismatch_q    <= mismatch_d;
			depth_q       <= depth_d;
			close_brace_q <= close_brace_d;
			pos_q         <= pos_d;
			outcome_q     <= outcome_d;
			found_q       <= found_d;
			ended_q       <= ended_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_offset_only_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_FOUND |-> result.value_offset == 16'h0000)
		else $error("offset set on a result that is not found");

	a_stall_needs_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> s1_valid && result_valid_q)
		else $error("input stalled with no blocked word");

	a_done_is_decided: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> outcome_q != ST_SEARCHING)
		else $error("finished phase without an outcome");

	a_container_depth: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONTAINER |-> depth_q != '0)
		else $error("skipping a container at depth zero");
`endif

endmodule
